>>> sv/double_ended_queue_ring_assert.svh
// Assertion macros used by the deque top level for its checks.
`ifndef DOUBLE_ENDED_QUEUE_RING_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_RING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define DEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed in the following cycle");

`endif

>>> sv/deq_pkg.sv
`timescale 1ns / 1ps
// Types, codes and default sizes shared by the deque files.
package deq_pkg;

    // Default storage sizes and the fixed widths of the item fields.
    localparam int DEF_DEPTH     = 64;
    localparam int DEF_WORD_BITS = 64;
    localparam int DATA_BITS     = 64;
    localparam int OPCODE_BITS   = 3;
    localparam int STATUS_BITS   = 2;
    localparam int OCC_BITS      = 7;

    // Input item opcodes.
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP_FWD   = 3'd4,
        OP_DUMP_BWD   = 3'd5
    } t_opcode;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH_FRONT,
        DP_PUSH_BACK,
        DP_POP_FRONT,
        DP_POP_BACK,
        DP_DUMP_FWD,
        DP_DUMP_BWD,
        DP_DUMP_NEXT,
        DP_NO_WORD,
        DP_CAPTURE
    } t_dp_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic more;
    } t_dp_stat;

endpackage

>>> sv/deq_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the deque command and result channels.
interface deq_in_if;
    import deq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [DATA_BITS-1:0]   data_word;

    modport source (output valid, output opcode, output data_word, input ready);
    modport sink   (input valid, input opcode, input data_word, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DATA_BITS-1:0]   read_word;
    logic                   item_valid;
    logic [STATUS_BITS-1:0] status;
    logic [OCC_BITS-1:0]    occupancy;
    logic                   last_of_run;

    modport source (output valid, output read_word, output item_valid, output status,
                    output occupancy, output last_of_run, input ready);
    modport sink   (input valid, input read_word, input item_valid, input status,
                    input occupancy, input last_of_run, output ready);
endinterface

>>> sv/deq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data valid the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/deq_ctrl.sv
`timescale 1ns / 1ps
// Deque controller: takes one item at a time and sequences the datapath.
module deq_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [deq_pkg::OPCODE_BITS-1:0] i_opcode,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  deq_pkg::t_dp_stat               i_stat,
    output deq_pkg::t_dp_cmd                o_cmd
);
    import deq_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_opcode w_op;

    assign w_op = t_opcode'(i_opcode);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '{op: DP_NOP, status: ST_OK};
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_state = S_HOLD;
                            if (i_stat.full) begin
                                o_cmd = '{op: DP_NO_WORD, status: ST_FULL};
                            end else if (w_op == OP_PUSH_FRONT) begin
                                o_cmd.op = DP_PUSH_FRONT;
                            end else begin
                                o_cmd.op = DP_PUSH_BACK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (i_stat.empty) begin
                                o_cmd   = '{op: DP_NO_WORD, status: ST_EMPTY};
                                n_state = S_HOLD;
                            end else begin
                                o_cmd.op = (w_op == OP_POP_FRONT) ? DP_POP_FRONT : DP_POP_BACK;
                                n_state  = S_READ;
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_BWD: begin
                            if (i_stat.empty) begin
                                o_cmd   = '{op: DP_NO_WORD, status: ST_OK};
                                n_state = S_HOLD;
                            end else begin
                                o_cmd.op = (w_op == OP_DUMP_FWD) ? DP_DUMP_FWD : DP_DUMP_BWD;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            // Unused opcodes are dropped without a result.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.op = DP_CAPTURE;
                n_state  = S_HOLD;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.more) begin
                        o_cmd.op = DP_DUMP_NEXT;
                        n_state  = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/deq_dp.sv
`timescale 1ns / 1ps
// Deque datapath: ring pointers, word store and the result register.
module deq_dp #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  deq_pkg::t_dp_cmd                i_cmd,
    output deq_pkg::t_dp_stat               o_stat,
    input  logic [deq_pkg::DATA_BITS-1:0]   i_data_word,
    output logic [deq_pkg::DATA_BITS-1:0]   o_read_word,
    output logic                            o_item_valid,
    output logic [deq_pkg::STATUS_BITS-1:0] o_status,
    output logic [deq_pkg::OCC_BITS-1:0]    o_occupancy,
    output logic                            o_last_of_run
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Ring position of a word at a given offset from the front.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic                 r_fwd, n_fwd;
    logic                 r_dumping, n_dumping;
    logic [DATA_BITS-1:0] r_read_word, n_read_word;
    logic                 r_item_valid, n_item_valid;
    t_status              r_status, n_status;
    logic [OCC_BITS-1:0]  r_occ, n_occ;
    logic                 r_last, n_last;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_rdata;
    logic [AW-1:0]        w_front_dec;
    logic [CW-1:0]        w_count_dec;
    logic [CW-1:0]        w_count_inc;
    logic [AW-1:0]        w_idx_inc;
    logic                 w_more;

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_word[WORD_BITS-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Pointer arithmetic shared by the operations.
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign w_count_dec = r_count - CW'(1);
    assign w_count_inc = r_count + CW'(1);
    assign w_idx_inc   = r_idx + AW'(1);
    assign w_more      = r_dumping && ((CW'(r_idx) + CW'(1)) != r_count);

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.more  = w_more;

    // Next values for the pointers, the store ports and the result.
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_fwd        = r_fwd;
        n_dumping    = r_dumping;
        n_read_word  = r_read_word;
        n_item_valid = r_item_valid;
        n_status     = r_status;
        n_occ        = r_occ;
        n_last       = r_last;
        w_we         = 1'b0;
        w_waddr      = r_front;
        w_re         = 1'b0;
        w_raddr      = r_front;
        case (i_cmd.op)
            DP_PUSH_FRONT, DP_PUSH_BACK: begin
                w_we = 1'b1;
                if (i_cmd.op == DP_PUSH_FRONT) begin
                    n_front = w_front_dec;
                    w_waddr = w_front_dec;
                end else begin
                    w_waddr = slot_of(r_front, r_count[AW-1:0]);
                end
                n_count      = w_count_inc;
                n_read_word  = '0;
                n_item_valid = 1'b0;
                n_status     = ST_OK;
                n_occ        = OCC_BITS'(w_count_inc);
                n_last       = 1'b1;
            end
            DP_POP_FRONT: begin
                w_re      = 1'b1;
                w_raddr   = r_front;
                n_front   = slot_of(r_front, AW'(1));
                n_count   = w_count_dec;
                n_dumping = 1'b0;
            end
            DP_POP_BACK: begin
                w_re      = 1'b1;
                w_raddr   = slot_of(r_front, w_count_dec[AW-1:0]);
                n_count   = w_count_dec;
                n_dumping = 1'b0;
            end
            DP_DUMP_FWD, DP_DUMP_BWD: begin
                w_re      = 1'b1;
                n_idx     = '0;
                n_fwd     = (i_cmd.op == DP_DUMP_FWD);
                n_dumping = 1'b1;
                if (i_cmd.op == DP_DUMP_FWD) begin
                    w_raddr = r_front;
                end else begin
                    w_raddr = slot_of(r_front, w_count_dec[AW-1:0]);
                end
            end
            DP_DUMP_NEXT: begin
                w_re  = 1'b1;
                n_idx = w_idx_inc;
                if (r_fwd) begin
                    w_raddr = slot_of(r_front, w_idx_inc);
                end else begin
                    w_raddr = slot_of(r_front, w_count_dec[AW-1:0] - w_idx_inc);
                end
            end
            DP_NO_WORD: begin
                n_read_word  = '0;
                n_item_valid = 1'b0;
                n_status     = i_cmd.status;
                n_occ        = OCC_BITS'(r_count);
                n_last       = 1'b1;
            end
            DP_CAPTURE: begin
                n_read_word  = DATA_BITS'(w_rdata);
                n_item_valid = 1'b1;
                n_status     = ST_OK;
                n_occ        = OCC_BITS'(r_count);
                n_last       = !w_more;
                // The dump ends with its last word, so later items see no more to send.
                n_dumping    = w_more;
            end
            default: begin
                n_front = r_front;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_dumping <= 1'b0;
        end else begin
            r_front   <= n_front;
            r_count   <= n_count;
            r_dumping <= n_dumping;
        end
    end

    // Dump position and result payload.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_fwd        <= n_fwd;
        r_read_word  <= n_read_word;
        r_item_valid <= n_item_valid;
        r_status     <= n_status;
        r_occ        <= n_occ;
        r_last       <= n_last;
    end

    assign o_read_word   = r_read_word;
    assign o_item_valid  = r_item_valid;
    assign o_status      = r_status;
    assign o_occupancy   = r_occ;
    assign o_last_of_run = r_last;

endmodule

>>> sv/double_ended_queue_ring.sv
`timescale 1ns / 1ps
// Top level of the ring-buffer double-ended queue.
//
// A bounded deque of DEPTH words held in a single-port-per-side RAM used as a
// ring. The block works on one command item at a time: a push, or any rejected
// command (push to full, pop from empty, empty dump), gives its result in the
// cycle after acceptance, and the next command is taken in the cycle after the
// result is taken. A successful pop passes through the read state first, as the
// word comes from the registered read port of the store. A dump of n words
// gives n results, each word needing its own read before it reaches the
// result register, and takes no command meanwhile. Unused opcodes are
// consumed without a result.
`include "double_ended_queue_ring_assert.svh"

module double_ended_queue_ring #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input logic     i_clk,
    input logic     i_rst_n,
    deq_in_if.sink  i_cmd,
    deq_out_if.source o_res
);
    import deq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_opcode    (i_cmd.opcode),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    deq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_data_word   (i_cmd.data_word),
        .o_read_word   (o_res.read_word),
        .o_item_valid  (o_res.item_valid),
        .o_status      (o_res.status),
        .o_occupancy   (o_res.occupancy),
        .o_last_of_run (o_res.last_of_run)
    );

    // Checks on the controller and result register.
    `DEQ_ASSERT_SAME(a_one_item_at_a_time, i_clk, i_rst_n, o_res.valid, !i_cmd.ready)
    `DEQ_ASSERT_SAME(a_occupancy_bounded, i_clk, i_rst_n, o_res.valid, o_res.occupancy <= OCC_BITS'(DEPTH))
    `DEQ_ASSERT_SAME(a_error_has_no_word, i_clk, i_rst_n, o_res.valid && (o_res.status != ST_OK), !o_res.item_valid && o_res.last_of_run)
    `DEQ_ASSERT_NEXT(a_dump_continues, i_clk, i_rst_n, o_res.valid && o_res.ready && !o_res.last_of_run, !i_cmd.ready && !o_res.valid)

endmodule
